// ===== rtl/bbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbs_pkg
// Shared widths, register indexes and operation codes of the bilinear
// bitmap scale unit.
// ----------------------------------------------------------------------------
package bbs_pkg;

   // fixed field widths
   localparam int COORD_W    = 10;
   localparam int STEP_W     = 24;
   localparam int SIZE_W     = 7;
   localparam int PIX_W      = 8;
   localparam int POS_W      = COORD_W + STEP_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   typedef logic [PIX_W-1:0] pixel_type;

   // operation codes
   localparam logic OP_WRITE   = 1'b0;
   localparam logic OP_REQUEST = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_X_STEP     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_STEP     = 2'd3;

   // register reset values
   localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;
   localparam logic [STEP_W-1:0] STEP_RESET = 24'd65536;

endpackage

// ===== rtl/bilinear_bitmap_scale_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_bitmap_scale_unit
// Holds an 8-bit source bitmap and returns bilinearly interpolated
// destination pixels for destination coordinates, fixed point throughout.
//
//   channel  direction  handshake              fields
//   req      in         req_valid/req_ready    op, x_coord, y_coord, pixel_in
//   rsp      out        rsp_valid/rsp_ready    pixel_out
//   csr      in         csr_write_en           csr_index, csr_wdata
//
// One item per clock sustained while the response side takes pixels; a
// request passes stages a, b, c, d and e before its pixel appears. The rate
// comes from the store split into four banks by column and row parity, so
// the four neighbours are read in the same cycle. A write lands in the store
// as it leaves stage b, the same stage where requests read, so order is kept.
// Reset clears the valid bits and the registers; the bitmap is not cleared.
// Each stage holds while the stage after it is full and not moving.
// ----------------------------------------------------------------------------
module bilinear_bitmap_scale_unit
   import bbs_pkg::*;
#(
   parameter int MAX_SIDE  = 64,
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_op,
   input  logic [COORD_W-1:0]    req_x_coord,
   input  logic [COORD_W-1:0]    req_y_coord,
   input  logic [PIX_W-1:0]      req_pixel_in,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [PIX_W-1:0]      rsp_pixel_out,
   // register write port
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CW    = $clog2(MAX_SIDE);
   localparam int HW    = CW - 1;
   localparam int HALF  = (MAX_SIDE + 1) / 2;
   localparam int BANK_DEPTH = HALF * HALF;
   localparam int AW    = $clog2(BANK_DEPTH);
   localparam int RW    = PIX_W + FRAC_BITS;
   localparam int SW    = PIX_W + 2 * FRAC_BITS;
   localparam logic [FRAC_BITS:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

   function automatic logic [AW-1:0] bank_addr(input logic [HW-1:0] row_half,
                                                input logic [HW-1:0] col_half);
      bank_addr = AW'(row_half) * AW'(HALF) + AW'(col_half);
   endfunction

   // configuration registers
   logic [SIZE_W-1:0] src_width_ff;
   logic [SIZE_W-1:0] src_height_ff;
   logic [STEP_W-1:0] x_step_ff;
   logic [STEP_W-1:0] y_step_ff;

   // stage enables
   logic en_a, en_b, en_c, en_d, en_e;

   // stage a: products
   logic               v_a_ff;
   logic               op_a_ff;
   logic [COORD_W-1:0] x_a_ff, y_a_ff;
   logic [PIX_W-1:0]   pix_a_ff;
   logic [POS_W-1:0]   pos_x_a_ff, pos_y_a_ff;
   logic [POS_W-1:0]   pos_x_in, pos_y_in;

   // stage b: store addresses
   logic                 v_b_ff;
   logic                 op_b_ff;
   logic                 wr_ok_b_ff, wr_ok_in;
   logic [1:0]           wr_bank_b_ff, wr_bank_in;
   logic [AW-1:0]        wr_addr_b_ff, wr_addr_in;
   logic [PIX_W-1:0]     wr_data_b_ff;
   logic [AW-1:0]        rd_addr_b_ff [4];
   logic [AW-1:0]        rd_addr_in [4];
   logic                 x0_odd_b_ff, x1_odd_b_ff, y0_odd_b_ff, y1_odd_b_ff;
   logic [FRAC_BITS-1:0] fx_b_ff, fy_b_ff;

   logic [FRAC_BITS-1:0] fx_in, fy_in;
   logic                 x0_odd_in, x1_odd_in, y0_odd_in, y1_odd_in;
   logic [HW-1:0]        x_even_half, x_odd_half, y_even_half, y_odd_half;

   // stage c: store data
   logic                 v_c_ff;
   logic                 x0_odd_c_ff, x1_odd_c_ff, y0_odd_c_ff, y1_odd_c_ff;
   logic [FRAC_BITS-1:0] fx_c_ff, fy_c_ff;
   logic [PIX_W-1:0]     ram_q [4];
   logic [3:0]           ram_we;
   pixel_type            p00, p10, p01, p11;
   logic [FRAC_BITS:0]   wx0;
   logic [RW-1:0]        r0_in, r1_in;

   // stage d: row mixes
   logic                 v_d_ff;
   logic [RW-1:0]        r0_d_ff, r1_d_ff;
   logic [FRAC_BITS-1:0] fy_d_ff;
   logic [FRAC_BITS:0]   wy0;
   logic [SW-1:0]        sum_in;

   // stage e: output register
   logic                 v_e_ff;
   pixel_type            pix_e_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= SIZE_RESET;
         src_height_ff <= SIZE_RESET;
         x_step_ff     <= STEP_RESET;
         y_step_ff     <= STEP_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_SRC_WIDTH:  src_width_ff  <= csr_wdata[SIZE_W-1:0];
            CSR_SRC_HEIGHT: src_height_ff <= csr_wdata[SIZE_W-1:0];
            CSR_X_STEP:     x_step_ff     <= csr_wdata[STEP_W-1:0];
            CSR_Y_STEP:     y_step_ff     <= csr_wdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // stall chain: a stage loads when empty or when its item moves on
   assign en_e      = !v_e_ff || rsp_ready;
   assign en_d      = !v_d_ff || en_e;
   assign en_c      = !v_c_ff || en_d;
   assign en_b      = !v_b_ff || en_c;
   assign en_a      = !v_a_ff || en_b;
   assign req_ready = en_a;

   // valid bits; writes leave the pipe after stage b
   always_ff @(posedge clock) begin
      if (reset) begin
         v_a_ff <= 1'b0;
         v_b_ff <= 1'b0;
         v_c_ff <= 1'b0;
         v_d_ff <= 1'b0;
         v_e_ff <= 1'b0;
      end else begin
         if (en_a) v_a_ff <= req_valid;
         if (en_b) v_b_ff <= v_a_ff;
         if (en_c) v_c_ff <= v_b_ff && (op_b_ff == OP_REQUEST);
         if (en_d) v_d_ff <= v_c_ff;
         if (en_e) v_e_ff <= v_d_ff;
      end
   end

   // stage a: coordinate times step on both axes
   assign pos_x_in = POS_W'(req_x_coord) * POS_W'(x_step_ff);
   assign pos_y_in = POS_W'(req_y_coord) * POS_W'(y_step_ff);

   always_ff @(posedge clock) begin
      if (en_a) begin
         op_a_ff    <= req_op;
         x_a_ff     <= req_x_coord;
         y_a_ff     <= req_y_coord;
         pix_a_ff   <= req_pixel_in;
         pos_x_a_ff <= pos_x_in;
         pos_y_a_ff <= pos_y_in;
      end
   end

   // stage b: neighbour mapping per axis
   bbs_axis_map #(
      .MAX_SIDE  (MAX_SIDE),
      .FRAC_BITS (FRAC_BITS)
   ) u_map_x (
      .pos       (pos_x_a_ff),
      .size      (src_width_ff),
      .frac      (fx_in),
      .lo_odd    (x0_odd_in),
      .hi_odd    (x1_odd_in),
      .even_half (x_even_half),
      .odd_half  (x_odd_half)
   );

   bbs_axis_map #(
      .MAX_SIDE  (MAX_SIDE),
      .FRAC_BITS (FRAC_BITS)
   ) u_map_y (
      .pos       (pos_y_a_ff),
      .size      (src_height_ff),
      .frac      (fy_in),
      .lo_odd    (y0_odd_in),
      .hi_odd    (y1_odd_in),
      .even_half (y_even_half),
      .odd_half  (y_odd_half)
   );

   // bank read addresses, bank index is {row odd, column odd}
   always_comb begin
      rd_addr_in[0] = bank_addr(y_even_half, x_even_half);
      rd_addr_in[1] = bank_addr(y_even_half, x_odd_half);
      rd_addr_in[2] = bank_addr(y_odd_half,  x_even_half);
      rd_addr_in[3] = bank_addr(y_odd_half,  x_odd_half);
   end

   // write address, out-of-range writes are dropped
   always_comb begin
      wr_ok_in   = (32'(x_a_ff) < MAX_SIDE) && (32'(y_a_ff) < MAX_SIDE);
      wr_bank_in = {y_a_ff[0], x_a_ff[0]};
      wr_addr_in = bank_addr(y_a_ff[CW-1:1], x_a_ff[CW-1:1]);
   end

   always_ff @(posedge clock) begin
      if (en_b) begin
         op_b_ff      <= op_a_ff;
         wr_ok_b_ff   <= wr_ok_in;
         wr_bank_b_ff <= wr_bank_in;
         wr_addr_b_ff <= wr_addr_in;
         wr_data_b_ff <= pix_a_ff;
         rd_addr_b_ff <= rd_addr_in;
         x0_odd_b_ff  <= x0_odd_in;
         x1_odd_b_ff  <= x1_odd_in;
         y0_odd_b_ff  <= y0_odd_in;
         y1_odd_b_ff  <= y1_odd_in;
         fx_b_ff      <= fx_in;
         fy_b_ff      <= fy_in;
      end
   end

   // four parity banks, writes and reads both happen as stage b moves on
   for (genvar b = 0; b < 4; b++) begin : g_bank
      assign ram_we[b] = v_b_ff && (op_b_ff == OP_WRITE) && wr_ok_b_ff && en_c &&
                         (wr_bank_b_ff == 2'(b));

      bbs_ram #(
         .WIDTH (PIX_W),
         .DEPTH (BANK_DEPTH)
      ) u_bank (
         .clock   (clock),
         .wr_en   (ram_we[b]),
         .wr_addr (wr_addr_b_ff),
         .wr_data (wr_data_b_ff),
         .rd_en   (en_c),
         .rd_addr (rd_addr_b_ff[b]),
         .rd_data (ram_q[b])
      );
   end

   always_ff @(posedge clock) begin
      if (en_c) begin
         x0_odd_c_ff <= x0_odd_b_ff;
         x1_odd_c_ff <= x1_odd_b_ff;
         y0_odd_c_ff <= y0_odd_b_ff;
         y1_odd_c_ff <= y1_odd_b_ff;
         fx_c_ff     <= fx_b_ff;
         fy_c_ff     <= fy_b_ff;
      end
   end

   // stage c: pick neighbours from banks and mix along x
   always_comb begin
      p00   = ram_q[{y0_odd_c_ff, x0_odd_c_ff}];
      p10   = ram_q[{y0_odd_c_ff, x1_odd_c_ff}];
      p01   = ram_q[{y1_odd_c_ff, x0_odd_c_ff}];
      p11   = ram_q[{y1_odd_c_ff, x1_odd_c_ff}];
      wx0   = FRAC_ONE - {1'b0, fx_c_ff};
      r0_in = RW'(wx0) * RW'(p00) + RW'(fx_c_ff) * RW'(p10);
      r1_in = RW'(wx0) * RW'(p01) + RW'(fx_c_ff) * RW'(p11);
   end

   always_ff @(posedge clock) begin
      if (en_d) begin
         r0_d_ff <= r0_in;
         r1_d_ff <= r1_in;
         fy_d_ff <= fy_c_ff;
      end
   end

   // stage d: mix along y, keep the integer byte
   always_comb begin
      wy0    = FRAC_ONE - {1'b0, fy_d_ff};
      sum_in = SW'(wy0) * SW'(r0_d_ff) + SW'(fy_d_ff) * SW'(r1_d_ff);
   end

   always_ff @(posedge clock) begin
      if (en_e) begin
         pix_e_ff <= sum_in[SW-1 -: PIX_W];
      end
   end

   assign rsp_valid     = v_e_ff;
   assign rsp_pixel_out = pix_e_ff;

   // a write never reaches the arithmetic stages
   a_write_drops: assert property (@(posedge clock) disable iff (reset)
      v_b_ff && (op_b_ff == OP_WRITE) && en_c |=> !v_c_ff)
      else $error("write item entered the mixing stages");

   // a request leaving the address stage always enters the data stage
   a_request_moves: assert property (@(posedge clock) disable iff (reset)
      v_b_ff && (op_b_ff == OP_REQUEST) && en_c |=> v_c_ff)
      else $error("request lost between address and data stages");

   // at most one bank is written per cycle
   a_one_bank_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0(ram_we))
      else $error("more than one bank written");

   // a blocked row-mix stage holds its item
   a_mix_holds: assert property (@(posedge clock) disable iff (reset)
      v_d_ff && !en_e |=> v_d_ff && $stable(r0_d_ff) && $stable(r1_d_ff))
      else $error("row-mix stage changed while stalled");

endmodule

// ===== rtl/bbs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbs_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read and a read enable that holds the output.
// ----------------------------------------------------------------------------
module bbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bbs_axis_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbs_axis_map
// Maps a fixed-point source position on one axis to its two neighbours
// (floor saturated to the last line, ceil clamped at the edge), their
// bank parities, their half indexes inside the even and odd banks, and
// the fraction.
// ----------------------------------------------------------------------------
module bbs_axis_map
   import bbs_pkg::*;
#(
   parameter int MAX_SIDE  = 64,
   parameter int FRAC_BITS = 16
) (
   input  logic [POS_W-1:0]           pos,
   input  logic [SIZE_W-1:0]          size,
   output logic [FRAC_BITS-1:0]       frac,
   output logic                       lo_odd,
   output logic                       hi_odd,
   output logic [$clog2(MAX_SIDE)-2:0] even_half,
   output logic [$clog2(MAX_SIDE)-2:0] odd_half
);

   localparam int CW   = $clog2(MAX_SIDE);
   localparam int HW   = CW - 1;
   localparam int FL_W = POS_W - FRAC_BITS;
   localparam int SZ_W = (CW + 1 > SIZE_W) ? CW + 1 : SIZE_W;

   logic [SZ_W-1:0] size_ext;
   logic [SZ_W-1:0] size_eff;
   logic [SZ_W-1:0] last_ext;
   logic [CW-1:0]   last;
   logic [FL_W-1:0] floor_pos;
   logic [CW-1:0]   lo;
   logic [CW-1:0]   hi;
   logic            at_edge;

   // size in use, forced into 1..MAX_SIDE
   always_comb begin
      size_ext = SZ_W'(size);
      if (size == '0) begin
         size_eff = SZ_W'(1);
      end else if (size_ext > SZ_W'(MAX_SIDE)) begin
         size_eff = SZ_W'(MAX_SIDE);
      end else begin
         size_eff = size_ext;
      end
      last_ext = size_eff - SZ_W'(1);
      last     = last_ext[CW-1:0];
   end

   // floor saturation and ceil neighbour
   always_comb begin
      floor_pos = pos[POS_W-1:FRAC_BITS];
      if (floor_pos > FL_W'(last)) begin
         lo = last;
      end else begin
         lo = floor_pos[CW-1:0];
      end
      at_edge = (lo == last);
      hi      = at_edge ? lo : lo + CW'(1);
   end

   // bank indexes: odd neighbour always sits at lo/2, even one moves up
   // when lo is odd and the ceil is a distinct column
   always_comb begin
      lo_odd   = lo[0];
      hi_odd   = hi[0];
      odd_half = lo[CW-1:1];
      if (lo[0] && !at_edge) begin
         even_half = odd_half + HW'(1);
      end else begin
         even_half = odd_half;
      end
      frac = pos[FRAC_BITS-1:0];
   end

endmodule

// ===== test/bbs_scale_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbs_scale_checker
// Watches the request, response and register ports of the bilinear bitmap
// scale unit, keeps its own copy of the source bitmap and registers, works
// out the pixel each request must return and compares it with every
// response transfer in order.
// ----------------------------------------------------------------------------
module bbs_scale_checker
   import bbs_pkg::*;
#(
   parameter int MAX_SIDE  = 64,
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic                  req_op,
   input  logic [COORD_W-1:0]    req_x_coord,
   input  logic [COORD_W-1:0]    req_y_coord,
   input  logic [PIX_W-1:0]      req_pixel_in,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [PIX_W-1:0]      rsp_pixel_out,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending
);

   // shadow of the bitmap and the registers
   pixel_type         bitmap [MAX_SIDE*MAX_SIDE];
   logic [SIZE_W-1:0] width_reg;
   logic [SIZE_W-1:0] height_reg;
   logic [STEP_W-1:0] xstep_reg;
   logic [STEP_W-1:0] ystep_reg;
   pixel_type         expected_pixels [$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   task automatic report_mismatch(input string what);
      $display("checker: %s at %0t ns", what, $time);
      fail_count++;
   endtask

   // size register as the block uses it: zero acts as one, large as full side
   function automatic int unsigned clamp_side(input logic [SIZE_W-1:0] size);
      if (size == 0) begin
         return 1;
      end
      if (size > MAX_SIDE) begin
         return MAX_SIDE;
      end
      return size;
   endfunction

   // floor, ceil and fraction of the source position on one axis
   function automatic void locate(input logic [COORD_W-1:0] coord,
                                  input logic [STEP_W-1:0] step,
                                  input logic [SIZE_W-1:0] size,
                                  output int unsigned lo, output int unsigned hi,
                                  output longint unsigned frac);
      longint unsigned pos;
      longint unsigned whole;
      int unsigned     last;
      last  = clamp_side(size) - 1;
      pos   = coord;
      pos   = pos * step;
      whole = pos >> FRAC_BITS;
      lo    = (whole > last) ? last : whole[31:0];
      hi    = (lo + 1 > last) ? lo : lo + 1;
      frac  = pos & ((64'd1 << FRAC_BITS) - 1);
   endfunction

   function automatic longint unsigned source_at(input int unsigned col,
                                                 input int unsigned row);
      return bitmap[row*MAX_SIDE + col];
   endfunction

   function automatic pixel_type interpolate_pixel(input logic [COORD_W-1:0] x,
                                                   input logic [COORD_W-1:0] y);
      int unsigned     x0, x1, y0, y1;
      longint unsigned fx, fy, one, upper, lower, sum;
      locate(x, xstep_reg, width_reg, x0, x1, fx);
      locate(y, ystep_reg, height_reg, y0, y1, fy);
      one   = 64'd1 << FRAC_BITS;
      upper = (one - fx) * source_at(x0, y0) + fx * source_at(x1, y0);
      lower = (one - fx) * source_at(x0, y1) + fx * source_at(x1, y1);
      sum   = (one - fy) * upper + fy * lower;
      return pixel_type'(sum >> (2 * FRAC_BITS));
   endfunction

   always @(posedge clock) begin
      pixel_type want;
      if (reset) begin
         width_reg  = SIZE_RESET;
         height_reg = SIZE_RESET;
         xstep_reg  = STEP_RESET;
         ystep_reg  = STEP_RESET;
      end else begin
         // register writes
         if (csr_write_en) begin
            case (csr_index)
               CSR_SRC_WIDTH:  width_reg  = csr_wdata[SIZE_W-1:0];
               CSR_SRC_HEIGHT: height_reg = csr_wdata[SIZE_W-1:0];
               CSR_X_STEP:     xstep_reg  = csr_wdata[STEP_W-1:0];
               CSR_Y_STEP:     ystep_reg  = csr_wdata[STEP_W-1:0];
               default: ;
            endcase
         end
         // response transfer against the oldest expected pixel
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch($sformatf("unexpected pixel_out %0h", rsp_pixel_out));
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_pixel_out !== want) begin
                  report_mismatch($sformatf("pixel_out %0h, want %0h", rsp_pixel_out, want));
               end
            end
         end
         // request transfer: store a pixel or predict one
         if (req_valid && req_ready) begin
            if (req_op == OP_REQUEST) begin
               expected_pixels.push_back(interpolate_pixel(req_x_coord, req_y_coord));
            end else if (req_x_coord < MAX_SIDE && req_y_coord < MAX_SIDE) begin
               bitmap[req_y_coord*MAX_SIDE + req_x_coord] = req_pixel_in;
            end
         end
      end
      pending = expected_pixels.size();
   end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the bilinear bitmap scale unit with pixel writes and pixel
// requests under a series of size and step settings, directed corners
// first and random traffic after, with random idle bursts on both
// channels. Every request is preceded by writes of any of its four source
// neighbours not yet stored. The checker instance does all comparing.
// ----------------------------------------------------------------------------
module testbench
   import bbs_pkg::*;
();

   localparam int SIDE         = 64;
   localparam int FRAC         = 16;
   localparam int SETTLE       = 12;
   localparam int ITEM_TARGET  = 1950;
   localparam int PHASES       = 12;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_op;
   logic [COORD_W-1:0]    req_x_coord;
   logic [COORD_W-1:0]    req_y_coord;
   logic [PIX_W-1:0]      req_pixel_in;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [PIX_W-1:0]      rsp_pixel_out;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    fail_count;
   int                    pending;

   // settings as last written, used to aim requests
   logic [SIZE_W-1:0] use_width  = SIZE_RESET;
   logic [SIZE_W-1:0] use_height = SIZE_RESET;
   logic [STEP_W-1:0] use_xstep  = STEP_RESET;
   logic [STEP_W-1:0] use_ystep  = STEP_RESET;
   bit                written [SIDE*SIDE];
   int                item_count = 0;
   bit                quiet      = 1'b0;
   int                gap_pct    = 20;
   int                stall_pct  = 20;
   int                stall_left = 0;

   bilinear_bitmap_scale_unit #(
      .MAX_SIDE  (SIDE),
      .FRAC_BITS (FRAC)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_x_coord   (req_x_coord),
      .req_y_coord   (req_y_coord),
      .req_pixel_in  (req_pixel_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pixel_out (rsp_pixel_out),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   bbs_scale_checker #(
      .MAX_SIDE  (SIDE),
      .FRAC_BITS (FRAC)
   ) i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_x_coord   (req_x_coord),
      .req_y_coord   (req_y_coord),
      .req_pixel_in  (req_pixel_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pixel_out (rsp_pixel_out),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending       (pending)
   );

   always #1 clock = ~clock;

   // response side back-pressure in random bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
      end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
         rsp_ready  <= 1'b0;
         stall_left = $urandom_range(1, 16) - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // one transfer on the request channel; returns at the accepting edge
   task automatic send_item(input logic op, input int unsigned x, input int unsigned y,
                            input int unsigned pix);
      int gap;
      @(negedge clock);
      gap = 0;
      if (!quiet && $urandom_range(0, 99) < gap_pct) begin
         gap = $urandom_range(1, 16);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_op       <= op;
      req_x_coord  <= COORD_W'(x);
      req_y_coord  <= COORD_W'(y);
      req_pixel_in <= PIX_W'(pix);
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic store_pixel(input int unsigned x, input int unsigned y, input int unsigned pix);
      send_item(OP_WRITE, x, y, pix);
      if (x < SIDE && y < SIDE) begin
         written[y*SIDE + x] = 1'b1;
         item_count++;
      end
   endtask

   // source cells touched on one axis, for filling before a request
   function automatic void span(input int unsigned coord, input logic [STEP_W-1:0] step,
                                input logic [SIZE_W-1:0] size,
                                output int unsigned lo, output int unsigned hi);
      longint unsigned pos;
      int unsigned     last;
      last = (size == 0) ? 0 : (size > SIDE) ? SIDE - 1 : size - 1;
      pos  = coord;
      pos  = (pos * step) >> FRAC;
      lo   = (pos > last) ? last : pos[31:0];
      hi   = (lo + 1 > last) ? lo : lo + 1;
   endfunction

   // request a pixel, first storing any neighbour never written
   task automatic request_pixel(input int unsigned x, input int unsigned y);
      int unsigned cols [2];
      int unsigned rows [2];
      span(x, use_xstep, use_width, cols[0], cols[1]);
      span(y, use_ystep, use_height, rows[0], rows[1]);
      foreach (rows[r]) begin
         foreach (cols[c]) begin
            if (!written[rows[r]*SIDE + cols[c]]) begin
               store_pixel(cols[c], rows[r], $urandom_range(0, 255));
            end
         end
      end
      send_item(OP_REQUEST, x, y, $urandom_range(0, 255));
      item_count++;
   endtask

   // hold the sender until every pixel has come back and the pipe is empty
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic configure(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                            input logic [STEP_W-1:0] xs, input logic [STEP_W-1:0] ys);
      drain();
      csr_write_en <= 1'b1;
      csr_index    <= CSR_SRC_WIDTH;
      csr_wdata    <= CSR_DATA_W'(w);
      @(negedge clock);
      csr_index    <= CSR_SRC_HEIGHT;
      csr_wdata    <= CSR_DATA_W'(h);
      @(negedge clock);
      csr_index    <= CSR_X_STEP;
      csr_wdata    <= CSR_DATA_W'(xs);
      @(negedge clock);
      csr_index    <= CSR_Y_STEP;
      csr_wdata    <= CSR_DATA_W'(ys);
      @(negedge clock);
      csr_write_en <= 1'b0;
      use_width  = w;
      use_height = h;
      use_xstep  = xs;
      use_ystep  = ys;
   endtask

   // sizes mostly small, sometimes full, zero or over range
   function automatic logic [SIZE_W-1:0] pick_size();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return SIZE_W'($urandom_range(SIDE + 1, 127));
         2, 3:    return SIZE_W'($urandom_range(9, SIDE));
         default: return SIZE_W'($urandom_range(1, 8));
      endcase
   endfunction

   function automatic logic [STEP_W-1:0] pick_step();
      case ($urandom_range(0, 6))
         0:       return '0;
         1:       return 24'h010000;
         2:       return 24'hFFFFFF;
         3:       return STEP_W'($urandom());
         4:       return STEP_W'($urandom_range(0, 24'h003FFF));
         default: return STEP_W'($urandom_range(0, 24'h03FFFF));
      endcase
   endfunction

   // coordinate that mostly lands inside the source, sometimes anywhere
   function automatic int unsigned pick_coord(input logic [STEP_W-1:0] step);
      longint unsigned reach;
      if (step == 0 || $urandom_range(0, 2) == 0) begin
         return $urandom_range(0, 1023);
      end
      reach = ((64'd1 * SIDE) << FRAC) / step + 1;
      if (reach > 1023) begin
         reach = 1023;
      end
      return $urandom_range(0, reach[31:0]);
   endfunction

   initial begin
      #2000000;
      $display("[bilinear_bitmap_scale_unit] ERROR");
      $finish;
   end

   initial begin
      int goal;
      int sel;
      clock        = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_op       = OP_WRITE;
      req_x_coord  = '0;
      req_y_coord  = '0;
      req_pixel_in = '0;
      rsp_ready    = 1'b0;
      csr_write_en = 1'b0;
      csr_index    = CSR_SRC_WIDTH;
      csr_wdata    = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // corners at reset settings: exact pixel, edge saturation, ignored writes
      store_pixel(0, 0, 8'hFF);
      store_pixel(1, 0, 8'h00);
      store_pixel(0, 1, 8'hAA);
      store_pixel(1, 1, 8'h55);
      request_pixel(0, 0);
      send_item(OP_WRITE, 64, 5, 8'h12);
      send_item(OP_WRITE, 1023, 1023, 8'hED);
      send_item(OP_WRITE, 5, 1023, 8'h3C);
      request_pixel(1023, 1023);
      store_pixel(63, 0, 8'h7E);
      request_pixel(63, 0);

      // half steps on a 2x2 source, ceil clamped at the far edge
      configure(2, 2, 24'h008000, 24'h008000);
      request_pixel(1, 1);
      request_pixel(3, 3);

      // zero step on x, largest step on y, size zero and over range
      configure(0, 127, 24'h000000, 24'hFFFFFF);
      request_pixel(1023, 1);
      request_pixel(0, 0);
      configure(127, 0, 24'hFFFFFF, 24'h000000);
      request_pixel(1, 1023);

      // single pixel source
      configure(1, 1, 24'h00C000, 24'h01_4000);
      request_pixel(512, 512);

      // full source, fractional steps
      configure(64, 64, 24'h01FFFF, 24'h00A5A5);
      request_pixel(17, 40);
      request_pixel(31, 63);

      // random settings and traffic, the last phase with no idling
      for (int p = 0; p < PHASES; p++) begin
         if (p == PHASES - 1) begin
            configure(pick_size(), pick_size(), pick_step(), pick_step());
            quiet = 1'b1;
         end else begin
            configure(pick_size(), pick_size(), pick_step(), pick_step());
            gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
            stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
         end
         goal = (p + 1) * ITEM_TARGET / PHASES;
         while (item_count < goal) begin
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
               request_pixel(pick_coord(use_xstep), pick_coord(use_ystep));
            end else if (sel < 90) begin
               store_pixel($urandom_range(0, $urandom_range(0, 1) ? 7 : SIDE - 1),
                           $urandom_range(0, $urandom_range(0, 1) ? 7 : SIDE - 1),
                           $urandom_range(0, 255));
            end else if (sel < 91) begin
               drain();
            end else begin
               // out of range writes, dropped by the block
               send_item(OP_WRITE, $urandom_range(0, 1) ? $urandom_range(SIDE, 1023)
                                                        : $urandom_range(0, 1023),
                         $urandom_range(SIDE, 1023), $urandom_range(0, 255));
            end
         end
      end

      drain();
      if (fail_count == 0) begin
         $display("[bilinear_bitmap_scale_unit] OK");
      end else begin
         $display("[bilinear_bitmap_scale_unit] ERROR");
      end
      $finish;
   end

endmodule
